// ===== rtl/indexed_list_store_defines.svh =====
// ----------------------------------------------------------------------------
// indexed_list_store assertion macros
// Shared property templates for the indexed list store RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Constants, operation and status codes and item types of the list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int KIND_W = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;

    localparam logic [KIND_W-1:0] K_GET      = 3'd0;
    localparam logic [KIND_W-1:0] K_INS_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] K_INS_TAIL = 3'd2;
    localparam logic [KIND_W-1:0] K_INS_AT   = 3'd3;
    localparam logic [KIND_W-1:0] K_DEL_AT   = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic [POS_W-1:0]        list_length;
    } t_out_item;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One list entry: shifts from a neighbor, loads a new value or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell
    import ils_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic [VAL_W-1:0] i_left,
    input  wire logic [VAL_W-1:0] i_right,
    output logic      [VAL_W-1:0] o_value,
    output logic      [VAL_W-1:0] o_read
);

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic [POS_W-1:0] idx_ext;
    logic             at_pos;
    logic             past_pos;

    assign idx_ext  = POS_W'(i_index);
    assign at_pos   = (idx_ext == i_cmd.pos);
    assign past_pos = (idx_ext > i_cmd.pos);

    always_comb begin
        n_val = r_val;
        priority if (i_cmd.shift_up && at_pos) begin
            n_val = i_cmd.value;
        end else if (i_cmd.shift_up && past_pos) begin
            n_val = i_left;
        end else if (i_cmd.shift_down && (at_pos || past_pos)) begin
            n_val = i_right;
        end else begin
            // hold
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    // drive the read bus only from the addressed cell
    assign o_read  = at_pos ? r_val : '0;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store.sv =====
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit entries
// kept in a chain of cells. For every item (get, insert at head, tail or
// index, delete at index) the cells move all later entries up or down in
// parallel and the single result is registered, so one item is accepted per
// cycle unless the input is stalled. The input stalls only while the output
// register holds a result that the downstream side is stalling.
// Each item yields status, the value read (-1 unless a get hit) and the
// list length after the operation.
// ----------------------------------------------------------------------------
// indexed_list_store
// Top level: operation decode, entry count, cell chain and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_store_defines.svh"

module indexed_list_store
    import ils_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in_item i_in_item,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out_item o_out_item
);

    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             accept;
    logic             is_ins;
    logic [POS_W-1:0] sel_pos;
    logic             rd_in_range;
    logic             ins_in_range;
    logic             full;
    logic             do_ins;
    logic             do_del;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] rd_bus;
    t_cell_cmd        cmd;

    logic [VAL_W-1:0] cell_val  [CAPACITY];
    logic [VAL_W-1:0] cell_read [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        is_ins  = 1'b0;
        sel_pos = i_in_item.position;
        unique case (i_in_item.kind)
            K_GET: begin
                sel_pos = i_in_item.position;
            end
            K_INS_HEAD: begin
                is_ins  = 1'b1;
                sel_pos = '0;
            end
            K_INS_TAIL: begin
                is_ins  = 1'b1;
                sel_pos = r_count;
            end
            K_INS_AT: begin
                is_ins  = 1'b1;
                sel_pos = i_in_item.position;
            end
            K_DEL_AT: begin
                sel_pos = i_in_item.position;
            end
            default: begin
                sel_pos = i_in_item.position;
            end
        endcase
    end

    assign rd_in_range  = (sel_pos < r_count);
    assign ins_in_range = (sel_pos <= r_count);
    assign full         = (r_count == POS_W'(CAPACITY));

    // range check before the full check for inserts
    always_comb begin
        priority if (is_ins) begin
            priority if (!ins_in_range) begin
                status = ST_RANGE;
            end else if (full) begin
                status = ST_FULL;
            end else begin
                status = ST_DONE;
            end
        end else if (i_in_item.kind == K_GET || i_in_item.kind == K_DEL_AT) begin
            status = rd_in_range ? ST_DONE : ST_RANGE;
        end else begin
            status = ST_RANGE;
        end
    end

    assign do_ins = accept && is_ins && ins_in_range && !full;
    assign do_del = accept && (i_in_item.kind == K_DEL_AT) && rd_in_range;

    assign cmd.shift_up   = do_ins;
    assign cmd.shift_down = do_del;
    assign cmd.pos        = sel_pos;
    assign cmd.value      = i_in_item.item_value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VAL_W-1:0] left;
            logic [VAL_W-1:0] right;
            if (g == 0) begin : g_head
                assign left = cmd.value;
            end else begin : g_mid_l
                assign left = cell_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign right = cell_val[g];
            end else begin : g_mid_r
                assign right = cell_val[g+1];
            end
            ils_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(g)),
                .i_cmd   (cmd),
                .i_left  (left),
                .i_right (right),
                .o_value (cell_val[g]),
                .o_read  (cell_read[g])
            );
        end
    endgenerate

    // at most one cell drives a nonzero read word
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_bus = rd_bus | cell_read[i];
        end
    end

    always_comb begin
        n_count = r_count;
        priority if (do_ins) begin
            n_count = r_count + POS_W'(1);
        end else if (do_del) begin
            n_count = r_count - POS_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (accept) begin
            n_out_valid       = 1'b1;
            n_out.read_value  = (i_in_item.kind == K_GET && rd_in_range) ? rd_bus : '1;
            n_out.status      = status;
            n_out.list_length = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ILS_ASSERT_NOW(a_count_max, 1'b1, r_count <= POS_W'(CAPACITY), "entry count above capacity")
    `ILS_ASSERT_NEXT(a_ins_grows, do_ins, r_count == $past(r_count) + POS_W'(1), "insert did not grow list")
    `ILS_ASSERT_NOW(a_full_len, r_out_valid && r_out.status == ST_FULL, r_out.list_length == POS_W'(CAPACITY), "full status with list not full")
    `ILS_ASSERT_NOW(a_fail_rd, r_out_valid && r_out.status != ST_DONE, r_out.read_value == '1, "failed item read value not -1")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: indexed list store testbench
// Sends list operations through the valid/stall input channel and keeps its
// own copy of the list to predict each item's status, read value and length.
// Results are compared in order at the output channel. Both channels pause at
// random, and the output side holds off once long enough to stall the input.
// ----------------------------------------------------------------------------

import ils_pkg::*;

class list_tracker;
    logic signed [VAL_W-1:0] entries [CAPACITY];
    int unsigned             count;
    t_out_item               pending [$];
    int unsigned             failures;

    function new();
        count    = 0;
        failures = 0;
    endfunction

    function logic [ST_W-1:0] insert_entry(int unsigned at, logic signed [VAL_W-1:0] v);
        if (at > count) begin
            return ST_RANGE;
        end
        if (count >= CAPACITY) begin
            return ST_FULL;
        end
        for (int i = count; i > at; i--) begin
            entries[i] = entries[i-1];
        end
        entries[at] = v;
        count++;
        return ST_DONE;
    endfunction

    // Apply one accepted item to the list and queue the result it should give.
    function void note_operation(t_in_item op);
        t_out_item r;
        r.read_value = -1;
        r.status     = ST_RANGE;
        case (op.kind)
            K_GET: begin
                if (op.position < count) begin
                    r.read_value = entries[op.position];
                    r.status     = ST_DONE;
                end
            end
            K_INS_HEAD: r.status = insert_entry(0, op.item_value);
            K_INS_TAIL: r.status = insert_entry(count, op.item_value);
            K_INS_AT:   r.status = insert_entry(op.position, op.item_value);
            K_DEL_AT: begin
                if (op.position < count) begin
                    for (int i = op.position; i + 1 < count; i++) begin
                        entries[i] = entries[i+1];
                    end
                    count--;
                    r.status = ST_DONE;
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.list_length = count[POS_W-1:0];
        pending.push_back(r);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (pending.size() == 0) begin
            failures++;
            $display("%0t: unexpected result rd=%0d st=%0d len=%0d", $time,
                     got.read_value, got.status, got.list_length);
            return;
        end
        want = pending.pop_front();
        if (got.read_value !== want.read_value || got.status !== want.status ||
            got.list_length !== want.list_length) begin
            failures++;
            $display("%0t: mismatch expected rd=%0d st=%0d len=%0d, actual rd=%0d st=%0d len=%0d",
                     $time, want.read_value, want.status, want.list_length,
                     got.read_value, got.status, got.list_length);
        end
    endfunction
endclass

module tb_top;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          PHASE_ITEMS    = 633;
    localparam int          SEGMENT_ITEMS  = 80;
    localparam int          HOLD_OFF_LEN   = 400;
    localparam logic [KIND_W-1:0] K_FIRST_UNUSED = 3'd5;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    list_tracker tracker = new();

    int unsigned sender_idle_pct   = 26;
    int unsigned receiver_idle_pct = 66;
    bit          hold_off_request  = 1'b0;
    int unsigned hold_left         = 0;
    int unsigned cycle_count       = 0;

    indexed_list_store u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random stall, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_out_item);
        end
    end

    function automatic t_in_item make_op(logic [KIND_W-1:0] kind, int unsigned pos,
                                         logic [VAL_W-1:0] v);
        t_in_item op;
        op.kind       = kind;
        op.position   = pos[POS_W-1:0];
        op.item_value = v;
        return op;
    endfunction

    // Grow mode favors inserts so the list reaches full; shrink mode drains it.
    function automatic t_in_item random_op(bit grow);
        t_in_item    op;
        int unsigned pick = $urandom_range(99);
        int unsigned sel  = $urandom_range(99);
        if (grow) begin
            op.kind = (pick < 10) ? K_GET : (pick < 30) ? K_INS_HEAD :
                      (pick < 50) ? K_INS_TAIL : (pick < 80) ? K_INS_AT :
                      (pick < 95) ? K_DEL_AT :
                      K_FIRST_UNUSED + KIND_W'($urandom_range(2));
        end else begin
            op.kind = (pick < 20) ? K_GET : (pick < 25) ? K_INS_HEAD :
                      (pick < 30) ? K_INS_TAIL : (pick < 40) ? K_INS_AT :
                      (pick < 95) ? K_DEL_AT :
                      K_FIRST_UNUSED + KIND_W'($urandom_range(2));
        end
        if (sel < 80) begin
            op.position = POS_W'($urandom_range(tracker.count));
        end else if (sel < 90) begin
            op.position = POS_W'($urandom_range(CAPACITY));
        end else begin
            op.position = POS_W'($urandom_range((1 << POS_W) - 1));
        end
        sel = $urandom_range(99);
        case (sel % 4)
            0: op.item_value = 32'h8000_0000;
            1: op.item_value = 32'h7fff_ffff;
            2: op.item_value = '1;
            default: op.item_value = '0;
        endcase
        if (sel >= 10) begin
            op.item_value = $urandom();
        end
        return op;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_in_item op);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= op;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        tracker.note_operation(op);
        @(negedge i_clk);
    endtask

    task automatic run_random(int unsigned n);
        for (int i = 0; i < n; i++) begin
            send_item(random_op(((i / SEGMENT_ITEMS) % 2) == 0));
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty list: everything out of range.
        send_item(make_op(K_GET, 0, 32'h1234_5678));
        send_item(make_op(K_DEL_AT, 0, '0));
        send_item(make_op(K_INS_AT, 1, 32'h5555_5555));
        // Insert at index equal to length appends.
        send_item(make_op(K_INS_AT, 0, '0));
        send_item(make_op(K_INS_HEAD, 0, 32'h8000_0000));
        send_item(make_op(K_INS_TAIL, 127, 32'h7fff_ffff));
        send_item(make_op(K_INS_AT, 1, '1));
        send_item(make_op(K_INS_AT, 64, 32'haaaa_aaaa));
        for (int p = 0; p <= 4; p++) begin
            send_item(make_op(K_GET, p, '1));
        end
        send_item(make_op(K_GET, 127, '0));
        send_item(make_op(K_DEL_AT, 127, '0));
        send_item(make_op(K_DEL_AT, 3, '0));
        send_item(make_op(K_DEL_AT, 0, '1));
        send_item(make_op(K_FIRST_UNUSED, 127, '1));
        send_item(make_op(K_FIRST_UNUSED + 3'd1, 0, '0));
        send_item(make_op(K_FIRST_UNUSED + 3'd2, 1, 32'h8000_0000));
        send_item(make_op(K_GET, 0, '0));
        send_item(make_op(K_GET, 1, '0));

        run_random(PHASE_ITEMS);
        sender_idle_pct   = 66;
        receiver_idle_pct = 26;
        run_random(PHASE_ITEMS);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_request  = 1'b1;
        run_random(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store.sv
tb/tb_top.sv
